[rtl/sstr_pkg.sv]
package sstr_pkg;

  localparam int unsigned FrameWords = 64;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned WordW      = 64;

  typedef struct packed {
    logic [6:0] hours;
    logic [6:0] minutes;
  } in_t;

  typedef struct packed {
    logic [AddrW-1:0] word_index;
    logic [WordW-1:0] pixel_bytes;
    logic             last;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic clr_wr;
    logic pix_wr;
    logic seg_next;
    logic emit_rd;
    logic emit_ld;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic addr_last;
    logic seg_lit;
    logic pix_last;
    logic seg_last;
    logic digit_last;
    logic out_valid;
    logic out_taken;
  } stat_t;

  typedef struct packed {
    logic [3:0] ox;
    logic [4:0] oy;
    logic [3:0] w;
    logic [3:0] h;
  } rect_t;

  // Lit segments of a decimal digit; bit s selects segment s of seg_rect.
  // Codes above nine light nothing.
  function automatic logic [6:0] seg_mask(logic [3:0] d);
    logic [6:0] m;
    case (d)
      4'd0:    m = 7'h7B;
      4'd1:    m = 7'h60;
      4'd2:    m = 7'h37;
      4'd3:    m = 7'h67;
      4'd4:    m = 7'h6C;
      4'd5:    m = 7'h4F;
      4'd6:    m = 7'h5F;
      4'd7:    m = 7'h61;
      4'd8:    m = 7'h7F;
      4'd9:    m = 7'h6F;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

  // Segment order: top, bottom, middle, upper-left, lower-left,
  // upper-right, lower-right.
  function automatic rect_t seg_rect(logic [2:0] s);
    rect_t r;
    case (s)
      3'd0:    r = '{ox: 4'd2,  oy: 5'd0,  w: 4'd10, h: 4'd3};
      3'd1:    r = '{ox: 4'd2,  oy: 5'd24, w: 4'd10, h: 4'd3};
      3'd2:    r = '{ox: 4'd2,  oy: 5'd12, w: 4'd10, h: 4'd3};
      3'd3:    r = '{ox: 4'd0,  oy: 5'd2,  w: 4'd3,  h: 4'd10};
      3'd4:    r = '{ox: 4'd0,  oy: 5'd14, w: 4'd3,  h: 4'd10};
      3'd5:    r = '{ox: 4'd11, oy: 5'd2,  w: 4'd3,  h: 4'd10};
      3'd6:    r = '{ox: 4'd11, oy: 5'd14, w: 4'd3,  h: 4'd10};
      default: r = '{ox: 4'd0,  oy: 5'd0,  w: 4'd1,  h: 4'd1};
    endcase
    return r;
  endfunction

endpackage

[rtl/sstr_ctrl.sv]
module sstr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sstr_pkg::stat_t stat_i,
  output sstr_pkg::cmd_t  cmd_o
);
  import sstr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_CLEAR     = 8'b0000_0010,
    S_SEG_CHK   = 8'b0000_0100,
    S_PIX_RD    = 8'b0000_1000,
    S_PIX_WR    = 8'b0001_0000,
    S_EMIT_RD   = 8'b0010_0000,
    S_EMIT_LD   = 8'b0100_0000,
    S_EMIT_WAIT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   paint_done;

  assign paint_done = stat_i.seg_last & stat_i.digit_last;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.addr_last) begin
          state_d = S_SEG_CHK;
        end
      end
      S_SEG_CHK: begin
        if (stat_i.seg_lit) begin
          state_d = S_PIX_RD;
        end else begin
          cmd_o.seg_next = 1'b1;
          if (paint_done) begin
            state_d = S_EMIT_RD;
          end
        end
      end
      S_PIX_RD: begin
        state_d = S_PIX_WR;
      end
      S_PIX_WR: begin
        cmd_o.pix_wr = 1'b1;
        if (stat_i.pix_last) begin
          cmd_o.seg_next = 1'b1;
          state_d        = paint_done ? S_EMIT_RD : S_SEG_CHK;
        end else begin
          state_d = S_PIX_RD;
        end
      end
      S_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
        state_d       = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (stat_i.out_taken) begin
          state_d = stat_i.addr_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // No new item may be taken while a word of the previous frame is pending.
  a_idle_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !stat_i.out_valid)
    else $error("idle with a frame word still pending");

  a_load_shows_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_ld |=> stat_i.out_valid)
    else $error("loaded frame word not presented");

  a_paint_quiet_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pix_wr || cmd_o.clr_wr) |-> !stat_i.out_valid)
    else $error("frame store written while a word is pending");

endmodule

[rtl/sstr_datapath.sv]
module sstr_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sstr_pkg::in_t   in_data_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output sstr_pkg::out_t  out_data_o,
  input  sstr_pkg::cmd_t  cmd_i,
  output sstr_pkg::stat_t stat_o
);
  import sstr_pkg::*;

  logic [WordW-1:0] mem [FrameWords];
  logic [WordW-1:0] rdata_q;

  logic [AddrW-1:0] addr_q;
  logic [1:0]       digit_q;
  logic [2:0]       seg_q;
  logic [3:0]       i_q, j_q;
  logic [3:0]       dig_q [4];
  logic             out_valid_q;
  out_t             out_q;

  logic [14:0] h_prod, m_prod;
  logic [3:0]  h_tens, m_tens;
  logic [6:0]  h_units, m_units;

  logic [3:0]       dval;
  logic [6:0]       mask;
  rect_t            rect;
  logic [4:0]       org_x;
  logic [6:0]       org_y;
  logic [5:0]       vx;
  logic [7:0]       vy;
  logic [4:0]       row;
  logic             clip;
  logic [AddrW-1:0] pix_word;
  logic [5:0]       pix_bit;
  logic             pix_last;
  logic             out_taken;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [WordW-1:0] wdata;

  // Division by ten through a reciprocal; exact for every seven-bit value.
  assign h_prod  = {8'd0, in_data_i.hours} * 15'd205;
  assign m_prod  = {8'd0, in_data_i.minutes} * 15'd205;
  assign h_tens  = h_prod[14:11];
  assign m_tens  = m_prod[14:11];
  assign h_units = in_data_i.hours - ({h_tens, 3'b000} + {2'b00, h_tens, 1'b0});
  assign m_units = in_data_i.minutes - ({m_tens, 3'b000} + {2'b00, m_tens, 1'b0});

  // Pixel address of the current point of the current segment.
  assign dval  = dig_q[digit_q];
  assign mask  = seg_mask(dval);
  assign rect  = seg_rect(seg_q);
  assign org_x = digit_q[0] ? 5'd17 : 5'd1;
  assign org_y = digit_q[1] ? 7'd75 : 7'd26;
  assign vx    = {1'b0, org_x} + {2'b00, rect.ox} + {2'b00, i_q};
  assign vy    = {1'b0, org_y} + {3'b000, rect.oy} + {4'b0000, j_q};
  assign clip  = vx[5] | vy[7];
  // The canvas is turned a quarter: virtual column becomes panel row 31-vx.
  assign row      = 5'd31 - vx[4:0];
  assign pix_word = {row[4:3], vy[6:3]};
  assign pix_bit  = {vy[2:0], row[2:0]};
  assign pix_last = (i_q == rect.w - 4'd1) && (j_q == rect.h - 4'd1);

  assign out_taken = out_valid_q & ~out_stall_i;

  assign we    = cmd_i.clr_wr | (cmd_i.pix_wr & ~clip);
  assign waddr = cmd_i.clr_wr ? addr_q : pix_word;
  assign wdata = cmd_i.clr_wr ? '0 : (rdata_q | ({{(WordW-1){1'b0}}, 1'b1} << pix_bit));
  assign raddr = cmd_i.emit_rd ? addr_q : pix_word;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      digit_q     <= '0;
      seg_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        addr_q  <= '0;
        digit_q <= '0;
        seg_q   <= '0;
        i_q     <= '0;
        j_q     <= '0;
      end else begin
        if (cmd_i.clr_wr || out_taken) begin
          addr_q <= addr_q + 6'd1;
        end
        if (cmd_i.seg_next) begin
          i_q <= '0;
          j_q <= '0;
          if (seg_q == 3'd6) begin
            seg_q   <= '0;
            digit_q <= digit_q + 2'd1;
          end else begin
            seg_q <= seg_q + 3'd1;
          end
        end else if (cmd_i.pix_wr) begin
          if (j_q == rect.h - 4'd1) begin
            j_q <= '0;
            i_q <= i_q + 4'd1;
          end else begin
            j_q <= j_q + 4'd1;
          end
        end
      end
      if (cmd_i.emit_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dig_q[0] <= h_tens;
      dig_q[1] <= h_units[3:0];
      dig_q[2] <= m_tens;
      dig_q[3] <= m_units[3:0];
    end
    if (cmd_i.emit_ld) begin
      out_q.word_index  <= addr_q;
      out_q.pixel_bytes <= rdata_q;
      out_q.last        <= (addr_q == AddrW'(FrameWords - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.addr_last  = (addr_q == AddrW'(FrameWords - 1));
  assign stat_o.seg_lit    = mask[seg_q];
  assign stat_o.pix_last   = pix_last;
  assign stat_o.seg_last   = (seg_q == 3'd6);
  assign stat_o.digit_last = (digit_q == 2'd3);
  assign stat_o.out_valid  = out_valid_q;
  assign stat_o.out_taken  = out_taken;

  a_word_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_taken && !out_q.last) |=> (addr_q == $past(addr_q) + 6'd1))
    else $error("word index did not advance after a taken word");

  a_last_matches_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == (out_q.word_index == AddrW'(FrameWords - 1))))
    else $error("last flag disagrees with word index");

  a_pixel_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pix_wr |-> (i_q < rect.w) && (j_q < rect.h))
    else $error("pixel counter outside its segment");

endmodule

[rtl/seven_segment_time_render.sv]
// An accepted item first clears the frame store word by word, then checks each
// segment slot (28) and paints each lit pixel (up to 840) with a read and a
// write in the read-modify-write loop on the frame store.
// The 64 words then leave one at a time, each read, loaded and held until taken;
// the next item is taken once the last word is.
// Reset clears control state only; the frame store is wiped at every item.
module seven_segment_time_render (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sstr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sstr_pkg::out_t out_data_o
);
  import sstr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sstr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sstr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

[test/tb_seven_segment_time_render.sv]
module tb_seven_segment_time_render;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1600000;
  localparam int unsigned MaxWait    = 12;
  localparam int unsigned RandomRuns = 100;

  // Lit segments per decimal digit, digit 0 in the lowest seven bits.
  localparam logic [69:0] SegMasks = {7'h6F, 7'h7F, 7'h61, 7'h5F, 7'h4F,
                                      7'h6C, 7'h67, 7'h37, 7'h60, 7'h7B};
  // One byte each of x offset, y offset, width and height; segment 0 lowest.
  localparam logic [223:0] SegRects = {32'h0B0E030A, 32'h0B02030A, 32'h000E030A,
                                       32'h0002030A, 32'h020C0A03, 32'h02180A03,
                                       32'h02000A03};

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  sstr_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  sstr_pkg::out_t out_data_o;

  logic [63:0]    frame_model [64];
  sstr_pkg::out_t words_due [$];
  sstr_pkg::out_t want;
  logic           no_gaps;
  int unsigned    cycle_count;
  int unsigned    frames_sent;
  int unsigned    words_checked;
  int unsigned    errors;

  seven_segment_time_render DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL seven_segment_time_render");
      $finish;
    end
  end

  // Fills a digit's lit segments, mapping the rotated canvas onto the pages.
  task automatic paint_digit(input int x, input int y, input int d);
    logic [6:0]  lit;
    logic [31:0] r;
    int vx, vy, row, col, word;
    if (d <= 9) begin
      lit = SegMasks[d*7 +: 7];
      for (int s = 0; s < 7; s++) begin
        if (lit[s]) begin
          r = SegRects[s*32 +: 32];
          for (int i = 0; i < int'(r[15:8]); i++) begin
            for (int j = 0; j < int'(r[7:0]); j++) begin
              vx = x + int'(r[31:24]) + i;
              vy = y + int'(r[23:16]) + j;
              if (vx < 32 && vy < 128) begin
                col = vy;
                row = 31 - vx;
                word = (row / 8) * 16 + col / 8;
                frame_model[word][(col % 8) * 8 + row % 8] = 1'b1;
              end
            end
          end
        end
      end
    end
  endtask

  task automatic render_time(input logic [6:0] hrs, input logic [6:0] mins);
    sstr_pkg::out_t w;
    for (int k = 0; k < 64; k++) frame_model[k] = '0;
    paint_digit(1, 26, int'(hrs) / 10);
    paint_digit(17, 26, int'(hrs) % 10);
    paint_digit(1, 75, int'(mins) / 10);
    paint_digit(17, 75, int'(mins) % 10);
    for (int k = 0; k < 64; k++) begin
      w.word_index  = k[5:0];
      w.pixel_bytes = frame_model[k];
      w.last        = (k == 63);
      words_due.push_back(w);
    end
  endtask

  // Valid drops at the falling edge after the item has been accepted.
  task automatic send_time(input logic [6:0] hrs, input logic [6:0] mins);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    in_data_i.hours   <= hrs;
    in_data_i.minutes <= mins;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    render_time(hrs, mins);
    frames_sent++;
    @(negedge clk_i) in_valid_i <= 1'b0;
  endtask

  task automatic wait_for_frames;
    while (words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_every_digit;
    for (int d = 0; d < 10; d++) send_time(7'(11 * d), 7'(99 - 11 * d));
  endtask

  task automatic test_field_extremes;
    send_time(7'd0, 7'd0);
    send_time(7'd99, 7'd99);
    send_time(7'd127, 7'd0);
    send_time(7'd0, 7'd127);
    send_time(7'd127, 7'd127);
  endtask

  // Tens digits of ten to twelve must leave their position blank.
  task automatic test_tens_above_nine;
    send_time(7'd100, 7'd119);
    send_time(7'd120, 7'd105);
    send_time(7'd113, 7'd88);
  endtask

  task automatic test_paused_sender;
    send_time(7'd12, 7'd34);
    send_time(7'd23, 7'd59);
    wait_for_frames();
    send_time(7'd8, 7'd1);
  endtask

  task automatic test_random_times;
    logic [6:0] hrs, mins;
    for (int n = 0; n < RandomRuns; n++) begin
      // Every so often a stretch with neither side idling.
      if (n % 30 == 20) no_gaps = 1'b1;
      if (n % 30 == 0) no_gaps = 1'b0;
      hrs  = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(100, 127))
                                         : 7'($urandom_range(0, 99));
      mins = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 59));
      send_time(hrs, mins);
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("word with none due: index %0d data %h last %b",
                                   out_data_o.word_index, out_data_o.pixel_bytes,
                                   out_data_o.last);
      end else begin
        want = words_due.pop_front();
        if (out_data_o.word_index !== want.word_index ||
            out_data_o.pixel_bytes !== want.pixel_bytes ||
            out_data_o.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: index exp %0d got %0d, last exp %b got %b",
                     want.word_index, out_data_o.word_index, want.last, out_data_o.last);
            $display("  pixels exp %h got %h", want.pixel_bytes, out_data_o.pixel_bytes);
          end
        end
      end
    end
  end

  // Receiver holds off each word for a random number of cycles.
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, MaxWait);
      repeat (hold) @(negedge clk_i) out_stall_i <= 1'b1;
      @(negedge clk_i) out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    no_gaps       = 1'b0;
    frames_sent   = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_every_digit();
    test_field_extremes();
    test_tens_above_nine();
    test_paused_sender();
    test_random_times();
    @(negedge clk_i) in_valid_i <= 1'b0;

    wait_for_frames();
    repeat (200) @(posedge clk_i);
    if (words_due.size() != 0) begin
      $display("%0d frame words never arrived", words_due.size());
    end

    $display("Rendered %0d times (all digits, out-of-range tens, extremes, random),",
             frames_sent);
    $display("checked %0d frame words under random idling and back-pressure; %0d errors.",
             words_checked, errors);
    if (errors == 0 && words_due.size() == 0) begin
      $display("PASS seven_segment_time_render");
    end else begin
      $display("FAIL seven_segment_time_render");
    end
    $finish;
  end

endmodule
